// ===== hdl/hbcm_pkg.sv =====
// Shared types and constants of the height band contour marker.
// Used by hbcm_cfg, the core top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package hbcm_pkg;

    // Grid limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int HGT_W      = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = COL_W + 1;   // frame_width register
    localparam int FH_W       = ROW_W + 1;   // frame_height register, step row counter
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Input beat kinds (tuser)
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_BAND_LOW     = 2'd0,
        REG_BAND_HIGH    = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } reg_idx_t;

    typedef logic signed [HGT_W-1:0] hgt_t;

    // One column of the 3x3 window: rows below, at and above the point
    typedef struct packed {
        hgt_t top;
        hgt_t mid;
        hgt_t bot;
    } col_vec_t;

    // Configuration as seen by the datapath (sizes already clamped)
    typedef struct packed {
        hgt_t            band_low;
        hgt_t            band_high;
        logic [FW_W-1:0] width;
        logic [FH_W-1:0] height;
        logic            restart;
    } cfg_t;

    // One step of the window pipeline, issued at the accept edge
    typedef struct packed {
        logic             virt;       // flush step: lower row replicated
        logic             emit;       // step completes a point
        logic             skip_fill;  // single-row frame: preload the first column
        hgt_t             sample;
        logic [COL_W-1:0] ci;
        logic [FH_W-1:0]  ri;
    } step_t;

endpackage

// ===== hdl/height_band_contour_marker_core.sv =====
// Height band contour marker: two cascaded line memories, a 3x3 column window, band compare.
// Depends on hbcm_pkg and hbcm_cfg.
// Throughput: one beat per cycle unless the output stalls, set by one-read one-write memories.
// Path of a result: stage 1 registers, stage 2 window registers, output register.
// Reset: counters, valids and the bypass flag reset; data registers and line memories do not.
`timescale 1ns / 1ps

module height_band_contour_marker_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] height
    input  logic [0:0]                  s_tuser,   // [0] op: 0 sample, 1 flush
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [0] mark, [10:1] col, [22:11] row, [23] zero
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hbcm_pkg::ADDR_W-1:0] paddr,
    input  logic [hbcm_pkg::DATA_W-1:0] pwdata,
    output logic [hbcm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int COL_W = hbcm_pkg::COL_W;
    localparam int ROW_W = hbcm_pkg::ROW_W;
    localparam int FW_W  = hbcm_pkg::FW_W;
    localparam int FH_W  = hbcm_pkg::FH_W;

    hbcm_pkg::cfg_t cfg;

    assign pready = 1'b1;

    hbcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s2_free, adv1, adv2;

    assign out_free = !out_valid_reg || m_tready;
    assign s2_free  = !v2_reg || out_free;
    assign adv2     = v2_reg && out_free;
    assign adv1     = v1_reg && s2_free;
    assign s_tready = !v1_reg || s2_free;

    // ------------------------------------------------------------------
    // Step counters at the accept edge
    // ------------------------------------------------------------------
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [FH_W-1:0]  in_row_reg, in_row_next;
    logic             full_reg, full_next;
    logic             is_flush, take, col_last, final_step, single_row;
    logic [FH_W-1:0]  row_inc;
    hbcm_pkg::step_t  step;

    assign is_flush   = (s_tuser[0] == hbcm_pkg::OP_FLUSH);
    assign take       = s_tvalid && s_tready && (is_flush ? full_reg : !full_reg);
    assign col_last   = ((FW_W'(in_col_reg) + FW_W'(1)) == cfg.width);
    assign row_inc    = in_row_reg + FH_W'(1);
    assign final_step = (in_row_reg == cfg.height + FH_W'(1)) && (in_col_reg == '0);
    assign single_row = (cfg.height == FH_W'(1));

    always_comb
    begin
        step.virt      = is_flush;
        step.sample    = s_tdata;
        step.ci        = in_col_reg;
        step.ri        = in_row_reg;
        step.emit      = ((in_row_reg != '0) && (in_col_reg != '0))
                         || ((in_row_reg >= FH_W'(2)) && (in_col_reg == '0));
        step.skip_fill = !is_flush && col_last && single_row;
    end

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        full_next   = full_reg;
        if (cfg.restart)
        begin
            in_col_next = '0;
            in_row_next = '0;
            full_next   = 1'b0;
        end
        else if (take)
        begin
            if (is_flush && final_step)
            begin
                in_col_next = '0;
                in_row_next = '0;
                full_next   = 1'b0;
            end
            else if (!col_last)
                in_col_next = in_col_reg + COL_W'(1);
            else
            begin
                in_col_next = '0;
                in_row_next = row_inc;
                if (!is_flush && (row_inc == cfg.height))
                    full_next = 1'b1;
                // single row: the first drain column is preloaded, skip it
                if (step.skip_fill)
                begin
                    if (cfg.width == FW_W'(1))
                        in_row_next = FH_W'(2);
                    else
                        in_col_next = COL_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line memories (read at accept, written when the step leaves)
    // ------------------------------------------------------------------
    hbcm_pkg::hgt_t   mem_a [hbcm_pkg::MAX_WIDTH];  // row above the newest
    hbcm_pkg::hgt_t   mem_b [hbcm_pkg::MAX_WIDTH];  // two rows above the newest
    hbcm_pkg::hgt_t   a_q, b_q, fa_reg, fb_reg;
    logic             fwd_reg, fwd_next;
    hbcm_pkg::step_t  st1_reg;
    hbcm_pkg::hgt_t   vmid, vtop_raw;
    hbcm_pkg::col_vec_t vec;

    always_comb
    begin
        vmid     = fwd_reg ? fa_reg : a_q;
        vtop_raw = fwd_reg ? fb_reg : b_q;
        vec.mid  = vmid;
        vec.bot  = st1_reg.virt ? vmid : st1_reg.sample;
        vec.top  = (st1_reg.ri == FH_W'(1)) ? vmid : vtop_raw;
    end

    // Same-address write and read in one edge: bypass the old memory data
    assign fwd_next = take ? (adv1 && (st1_reg.ci == in_col_reg)) : fwd_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            mem_a[st1_reg.ci] <= vec.bot;
            mem_b[st1_reg.ci] <= vec.mid;
        end
        if (take)
        begin
            a_q     <= mem_a[in_col_reg];
            b_q     <= mem_b[in_col_reg];
            fa_reg  <= vec.bot;
            fb_reg  <= vec.mid;
            st1_reg <= step;
        end
    end

    // Column window and point position
    hbcm_pkg::col_vec_t p1_reg, p2_reg, fill_vec, wl, wc, wr;
    hbcm_pkg::hgt_t     x0_reg, x0_val;
    logic [FH_W-1:0]    prow;
    logic [COL_W-1:0]   pcol;
    logic               plast;

    always_comb
    begin
        x0_val       = (st1_reg.ci == '0) ? vec.bot : x0_reg;
        fill_vec.top = x0_val;
        fill_vec.mid = x0_val;
        fill_vec.bot = x0_val;
        wc = p1_reg;
        if ((st1_reg.ci == COL_W'(1)) || ((st1_reg.ci == '0) && (cfg.width == FW_W'(1))))
            wl = p1_reg;
        else
            wl = p2_reg;
        if (st1_reg.ci == '0)
        begin
            wr   = p1_reg;
            pcol = COL_W'(cfg.width - FW_W'(1));
            prow = st1_reg.ri - FH_W'(2);
        end
        else
        begin
            wr   = vec;
            pcol = st1_reg.ci - COL_W'(1);
            prow = st1_reg.ri - FH_W'(1);
        end
        plast = (prow == cfg.height - FH_W'(1))
                && (FW_W'(pcol) == cfg.width - FW_W'(1));
    end

    // ------------------------------------------------------------------
    // Stage 2: window registers
    // ------------------------------------------------------------------
    hbcm_pkg::col_vec_t s2_l, s2_c, s2_r;
    logic [COL_W-1:0]   s2_col;
    logic [ROW_W-1:0]   s2_row;
    logic               s2_last;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            p2_reg <= p1_reg;
            p1_reg <= st1_reg.skip_fill ? fill_vec : vec;
            x0_reg <= x0_val;
            if (st1_reg.emit)
            begin
                s2_l    <= wl;
                s2_c    <= wc;
                s2_r    <= wr;
                s2_col  <= pcol;
                s2_row  <= prow[ROW_W-1:0];
                s2_last <= plast;
            end
        end
    end

    // Band rule on the registered window
    hbcm_pkg::hgt_t nb [8];
    hbcm_pkg::hgt_t z;
    logic           higher, lower, mark;

    always_comb
    begin
        nb[0] = s2_l.top;
        nb[1] = s2_l.mid;
        nb[2] = s2_l.bot;
        nb[3] = s2_c.top;
        nb[4] = s2_c.bot;
        nb[5] = s2_r.top;
        nb[6] = s2_r.mid;
        nb[7] = s2_r.bot;
        z      = s2_c.mid;
        higher = 1'b0;
        lower  = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (nb[i] > cfg.band_low)
                higher = 1'b1;
            if (nb[i] < cfg.band_high)
                lower = 1'b1;
        end
        mark = ((z >= cfg.band_low) && (z <= cfg.band_high))
               || ((z < cfg.band_low) && higher)
               || ((z > cfg.band_high) && lower);
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            m_tdata <= {1'b0, s2_row, s2_col, mark};
            m_tlast <= s2_last;
        end
    end

    assign m_tvalid = out_valid_reg;

    // Valid chain next values
    always_comb
    begin
        v1_next = take ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
        if (adv1 && st1_reg.emit)
            v2_next = 1'b1;
        else if (adv2)
            v2_next = 1'b0;
        else
            v2_next = v2_reg;
        if (adv2)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            full_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            full_reg      <= full_next;
            fwd_reg       <= fwd_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/hbcm_cfg.sv =====
// APB register block of the height band contour marker: band bounds and frame size.
// Depends on hbcm_pkg; gives the clamped sizes and a restart pulse on size writes.
`timescale 1ns / 1ps

module hbcm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hbcm_pkg::ADDR_W-1:0] paddr,
    input  logic [hbcm_pkg::DATA_W-1:0] pwdata,
    output logic [hbcm_pkg::DATA_W-1:0] prdata,
    output hbcm_pkg::cfg_t              cfg
);

    logic [hbcm_pkg::HGT_W-1:0] band_low_reg, band_low_next;
    logic [hbcm_pkg::HGT_W-1:0] band_high_reg, band_high_next;
    logic [hbcm_pkg::FW_W-1:0]  width_reg, width_next;
    logic [hbcm_pkg::FH_W-1:0]  height_reg, height_next;
    hbcm_pkg::reg_idx_t         idx;
    logic                       wr;

    assign idx = hbcm_pkg::reg_idx_t'(paddr[3:2]);
    assign wr  = psel && penable && pwrite;

    // Write decode
    always_comb
    begin
        band_low_next  = band_low_reg;
        band_high_next = band_high_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        cfg.restart    = 1'b0;
        if (wr)
        begin
            unique case (idx)
                hbcm_pkg::REG_BAND_LOW:     band_low_next  = pwdata[hbcm_pkg::HGT_W-1:0];
                hbcm_pkg::REG_BAND_HIGH:    band_high_next = pwdata[hbcm_pkg::HGT_W-1:0];
                hbcm_pkg::REG_FRAME_WIDTH:
                begin
                    width_next  = pwdata[hbcm_pkg::FW_W-1:0];
                    cfg.restart = 1'b1;
                end
                hbcm_pkg::REG_FRAME_HEIGHT:
                begin
                    height_next = pwdata[hbcm_pkg::FH_W-1:0];
                    cfg.restart = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg  <= '0;
            band_high_reg <= '0;
            width_reg     <= hbcm_pkg::FW_W'(1024);
            height_reg    <= hbcm_pkg::FH_W'(1024);
        end
        else
        begin
            band_low_reg  <= band_low_next;
            band_high_reg <= band_high_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            hbcm_pkg::REG_BAND_LOW:     prdata = hbcm_pkg::DATA_W'(band_low_reg);
            hbcm_pkg::REG_BAND_HIGH:    prdata = hbcm_pkg::DATA_W'(band_high_reg);
            hbcm_pkg::REG_FRAME_WIDTH:  prdata = hbcm_pkg::DATA_W'(width_reg);
            hbcm_pkg::REG_FRAME_HEIGHT: prdata = hbcm_pkg::DATA_W'(height_reg);
        endcase
    end

    // Clamp sizes to 1..MAX
    always_comb
    begin
        cfg.band_low  = band_low_reg;
        cfg.band_high = band_high_reg;
        if (width_reg == '0)
            cfg.width = hbcm_pkg::FW_W'(1);
        else if (width_reg > hbcm_pkg::FW_W'(hbcm_pkg::MAX_WIDTH))
            cfg.width = hbcm_pkg::FW_W'(hbcm_pkg::MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == '0)
            cfg.height = hbcm_pkg::FH_W'(1);
        else if (height_reg > hbcm_pkg::FH_W'(hbcm_pkg::MAX_HEIGHT))
            cfg.height = hbcm_pkg::FH_W'(hbcm_pkg::MAX_HEIGHT);
        else
            cfg.height = height_reg;
    end

endmodule

// ===== hdl/hbcm_checker.sv =====
// Port-level checker of the height band contour marker core, with its bind.
// Depends on hbcm_pkg and the ports of height_band_contour_marker_core.
`timescale 1ns / 1ps

module hbcm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [23:0]                 m_tdata,
    input logic                        m_tlast,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [hbcm_pkg::ADDR_W-1:0] paddr,
    input logic [hbcm_pkg::DATA_W-1:0] pwdata,
    input logic [hbcm_pkg::DATA_W-1:0] prdata
);

    // Stalled result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // No result beat while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result beat during reset");

    // A band_low write reads back right away
    a_band_low_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] == 2'd0)
        |=> (paddr[3:2] != 2'd0) || (prdata[15:0] == $past(pwdata[15:0])))
        else $error("band_low readback mismatch");

endmodule

bind height_band_contour_marker_core hbcm_checker u_hbcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
